[rtl/kld_pkg.sv]
// Shared types and constants for the thresholded KL divergence block.
// Used by the front end, queue, back end, top level and checker; no dependencies.
`default_nettype none

package kld_pkg;

   // Largest table index width supported; queue entries always carry this many bits.
   localparam int MAX_TABLE_BITS = 10;

   // Depth of the queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] LN2_Q16 = 16'd45426;
   localparam logic [31:0] THRESHOLD_RESET = 32'd6554;

   localparam int SUM_WIDTH = 48;
   localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH - 1){1'b1}}};
   localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH - 1){1'b0}}};

   // What the back end has to do with one pair.
   typedef enum logic [1:0] {
      OP_SKIP   = 2'd0,
      OP_ZERO_Q = 2'd1,
      OP_TERM   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_BELOW = 2'd0,
      STATUS_ABOVE = 2'd1,
      STATUS_FAULT = 2'd2
   } status_type;

   // One classified pair as it sits in the queue.
   typedef struct packed {
      logic [31:0]               p_value;
      op_type                    op;
      logic                      last_pair;
      logic [4:0]                exp_p;
      logic [4:0]                exp_q;
      logic [MAX_TABLE_BITS-1:0] idx_p;
      logic [MAX_TABLE_BITS-1:0] idx_q;
   } pair_type;

endpackage

`default_nettype wire

[rtl/kld_front.sv]
// Front end: accepts category pairs, classifies them and finds the leading-one
// position and table index of both weights. Depends on kld_pkg.
`default_nettype none

module kld_front #(
   parameter int LOG_TABLE_BITS = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [63:0]       req_tdata,
   input  wire logic              req_tlast,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output kld_pkg::pair_type      push_entry
);
   import kld_pkg::*;

   logic     entry_valid_ff;
   pair_type entry_ff;
   pair_type entry_in;
   logic     accept;

   function automatic logic [4:0] leading_one(input logic [31:0] x);
      logic [4:0] pos;
      pos = '0;
      for (int b = 0; b < 32; b++) begin
         if (x[b]) begin
            pos = 5'(b);
         end
      end
      return pos;
   endfunction

   // Bits just below the leading one, aligned to the table width.
   function automatic logic [MAX_TABLE_BITS-1:0] table_index(input logic [31:0] x,
                                                             input logic [4:0]  e);
      logic [31:0] mant;
      logic [31:0] shifted;
      mant = x ^ (32'd1 << e);
      if (e >= 5'(LOG_TABLE_BITS)) begin
         shifted = mant >> (e - 5'(LOG_TABLE_BITS));
      end else begin
         shifted = mant << (5'(LOG_TABLE_BITS) - e);
      end
      return MAX_TABLE_BITS'(shifted[LOG_TABLE_BITS-1:0]);
   endfunction

   always_comb begin
      logic [31:0] p;
      logic [31:0] q;
      p = req_tdata[31:0];
      q = req_tdata[63:32];
      entry_in.p_value   = p;
      entry_in.last_pair = req_tlast;
      entry_in.exp_p     = leading_one(p);
      entry_in.exp_q     = leading_one(q);
      entry_in.idx_p     = table_index(p, entry_in.exp_p);
      entry_in.idx_q     = table_index(q, entry_in.exp_q);
      if (p == 32'd0) begin
         entry_in.op = OP_SKIP;
      end else if (q == 32'd0) begin
         entry_in.op = OP_ZERO_Q;
      end else begin
         entry_in.op = OP_TERM;
      end
   end

   assign req_tready = !entry_valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            entry_valid_ff <= 1'b1;
         end else if (push_ready) begin
            entry_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign push_valid = entry_valid_ff;
   assign push_entry = entry_ff;

endmodule

`default_nettype wire

[rtl/kld_queue.sv]
// Short queue of classified pairs between the front end and the back end.
// Depends on kld_pkg for the entry type and depth.
`default_nettype none

module kld_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire kld_pkg::pair_type in_entry,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output kld_pkg::pair_type      out_entry
);
   import kld_pkg::*;

   pair_type                  mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff;
   logic                      push;
   logic                      pop;

   function automatic logic [QUEUE_PTR_BITS-1:0] next_ptr(input logic [QUEUE_PTR_BITS-1:0] ptr);
      if (ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign in_ready  = count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_entry = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         mem[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/kld_back.sv]
// Back end: log table lookup, ln2 scaling, weighting, accumulation and the
// thresholded result register. Depends on kld_pkg.
`default_nettype none

module kld_back #(
   parameter int LOG_TABLE_BITS = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [31:0]       threshold,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire kld_pkg::pair_type pop_entry,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [31:0]            rsp_tdata,
   output logic [1:0]             rsp_tuser
);
   import kld_pkg::*;

   localparam int TABLE_SIZE = 1 << LOG_TABLE_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_LN,
      ST_PROD,
      ST_ACC,
      ST_FINISH
   } state_type;

   // Fractional part of log2(1 + idx / TABLE_SIZE) in Q0.16 by repeated squaring.
   function automatic logic [15:0] frac_log2(input int unsigned idx);
      logic [63:0] x;
      logic [15:0] r;
      x = (64'd1 << 30) + (64'(idx) << (30 - LOG_TABLE_BITS));
      r = '0;
      for (int k = 15; k >= 0; k--) begin
         x = (x * x) >> 30;
         if (x >= (64'd1 << 31)) begin
            r[k] = 1'b1;
            x = x >> 1;
         end
      end
      return r;
   endfunction

   logic [15:0] log_rom [TABLE_SIZE];

   for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
      assign log_rom[g] = frac_log2(g);
   end

   state_type             state_ff;
   logic [31:0]           p_ff;
   logic                  last_ff;
   logic [4:0]            exp_p_ff;
   logic [4:0]            exp_q_ff;
   logic [15:0]           tab_p_ff;
   logic [15:0]           tab_q_ff;
   logic                  neg_ff;
   logic [20:0]           dmag_ff;
   logic [20:0]           lnmag_ff;
   logic [36:0]           tmag_ff;
   logic [SUM_WIDTH-1:0]  sum_ff;
   logic                  fault_ff;
   logic                  rsp_valid_ff;
   logic [31:0]           rsp_data_ff;
   status_type            rsp_status_ff;

   logic signed [5:0]     exp_diff;
   logic signed [21:0]    diff_in;
   logic [20:0]           dmag_in;
   logic [36:0]           ln_prod;
   logic [52:0]           w_prod;
   logic [SUM_WIDTH:0]    term_ext;
   logic [SUM_WIDTH:0]    sum_wide;
   logic [SUM_WIDTH-1:0]  sum_in;
   logic [SUM_WIDTH-1:0]  mag_in;
   logic                  below;
   logic                  out_free;
   logic                  result_load;

   always_comb begin
      exp_diff = $signed({1'b0, exp_p_ff}) - $signed({1'b0, exp_q_ff});
      diff_in  = $signed({exp_diff, 16'd0}) + $signed({6'd0, tab_p_ff})
                 - $signed({6'd0, tab_q_ff});
      dmag_in  = diff_in[21] ? 21'(-diff_in) : diff_in[20:0];
   end

   assign ln_prod = 37'(dmag_ff) * 37'(LN2_Q16);
   assign w_prod  = 53'(p_ff) * 53'(lnmag_ff);

   always_comb begin
      term_ext = {12'd0, tmag_ff};
      sum_wide = {sum_ff[SUM_WIDTH-1], sum_ff} + (neg_ff ? -term_ext : term_ext);
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_in = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_in = sum_wide[SUM_WIDTH-1:0];
      end
   end

   // Magnitude of the sum; the most negative value maps to 2^47, which still fits.
   assign mag_in   = sum_ff[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - sum_ff) : sum_ff;
   assign below    = mag_in < {16'd0, threshold};
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign pop_ready = state_ff == ST_IDLE;
   assign result_load = (state_ff == ST_FINISH) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  p_ff     <= pop_entry.p_value;
                  last_ff  <= pop_entry.last_pair;
                  exp_p_ff <= pop_entry.exp_p;
                  exp_q_ff <= pop_entry.exp_q;
                  tab_p_ff <= log_rom[pop_entry.idx_p[LOG_TABLE_BITS-1:0]];
                  tab_q_ff <= log_rom[pop_entry.idx_q[LOG_TABLE_BITS-1:0]];
                  if (pop_entry.op == OP_TERM && !fault_ff) begin
                     state_ff <= ST_DIFF;
                  end else begin
                     if (pop_entry.op == OP_ZERO_Q) begin
                        fault_ff <= 1'b1;
                     end
                     state_ff <= pop_entry.last_pair ? ST_FINISH : ST_IDLE;
                  end
               end
            end
            ST_DIFF: begin
               neg_ff   <= diff_in[21];
               dmag_ff  <= dmag_in;
               state_ff <= ST_LN;
            end
            ST_LN: begin
               lnmag_ff <= ln_prod[36:16];
               state_ff <= ST_PROD;
            end
            ST_PROD: begin
               tmag_ff  <= w_prod[52:16];
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               sum_ff   <= sum_in;
               state_ff <= last_ff ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
               if (out_free) begin
                  if (fault_ff) begin
                     rsp_data_ff   <= '0;
                     rsp_status_ff <= STATUS_FAULT;
                  end else if (below) begin
                     rsp_data_ff   <= mag_in[31:0];
                     rsp_status_ff <= STATUS_BELOW;
                  end else begin
                     rsp_data_ff   <= '0;
                     rsp_status_ff <= STATUS_ABOVE;
                  end
                  sum_ff   <= '0;
                  fault_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

[rtl/kl_divergence_threshold.sv]
// Top level of the thresholded Kullback-Leibler divergence block.
// Holds the threshold register and joins kld_front, kld_queue and kld_back; uses kld_pkg.
//
// The block takes pairs (p, q) of unsigned Q16.16 category weights, one pair per
// transfer, and sums p*ln(p/q) over a vector into a saturating signed 48-bit
// accumulator; ln(p/q) is built from leading-one positions and a fraction table
// of 2^LOG_TABLE_BITS entries, scaled by ln2. Pairs with p zero add nothing, and
// a zero q with nonzero p raises a sticky fault. The transfer marked by req_tlast
// produces exactly one result: the absolute sum with status 0 when it lies below
// the threshold, zero with status 1 when it does not, and zero with status 2 on a
// fault; the accumulator and fault then clear for the next vector. The front end
// accepts one transfer per cycle until its output register and the two-entry queue
// are full. The back end takes a contributing pair through table read, log
// difference, ln2 multiply, weight multiply and accumulate states in order, a
// skipped or faulting pair through its idle state alone, and a last pair on to a
// state that loads the result register once that register is free. It takes no
// new pair before it is back in idle, so its multiply sequence paces contributing
// pairs. Results wait in an output register while the front end keeps taking
// transfers. The threshold resets to 6554 (0.1) and is written over the csr
// channel, which is always ready; write it only while no vector is in progress.
`default_nettype none

module kl_divergence_threshold #(
   parameter int LOG_TABLE_BITS = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input pairs. tdata: p_value [31:0], q_value [63:32]. tlast: last_pair.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic        req_tlast,
   // Results. tdata: divergence [31:0]. tuser: status [1:0].
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,
   // Threshold write channel. data: divergence_threshold [31:0].
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);
   import kld_pkg::*;

   logic [31:0] threshold_ff;

   logic     push_valid;
   logic     push_ready;
   pair_type push_entry;
   logic     pop_valid;
   logic     pop_ready;
   pair_type pop_entry;

   // The register is a plain flop, so every write transfer completes at once.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_data;
      end
   end

   // Classification and leading-one search run one transfer per cycle unless a full queue holds them back.
   kld_front #(
      .LOG_TABLE_BITS(LOG_TABLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // The queue lets the front end run ahead while the back end is multiplying.
   kld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   // The back end owns the accumulator, the fault bit and the result register.
   kld_back #(
      .LOG_TABLE_BITS(LOG_TABLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .threshold  (threshold_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

[rtl/kld_checker.sv]
// Port-level checks for kl_divergence_threshold and the bind that attaches them.
// Depends on kld_pkg for status codes and the threshold reset value.
`default_nettype none

module kld_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [31:0] csr_data
);
   import kld_pkg::*;

   // Shadow of the threshold, tracked from write transfers.
   logic [31:0] thr_shadow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_shadow_ff <= THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_shadow_ff <= csr_data;
      end
   end

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Above-threshold and fault results carry a zero divergence.
   a_zero_on_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_ABOVE || rsp_tuser == STATUS_FAULT)
      |-> rsp_tdata == 32'd0)
      else $error("nonzero divergence with reject status");

   // An accepted result lies strictly below the threshold in force.
   a_below_threshold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_BELOW |-> rsp_tdata < thr_shadow_ff)
      else $error("divergence not below threshold");

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind kl_divergence_threshold kld_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_data   (csr_data)
);

`default_nettype wire

[tb/sv/kld_checker.sv]
// Scoreboard for the thresholded KL divergence block: watches the pair, result
// and threshold channels, predicts each result and compares it field by field.
// Depends on kld_pkg for the status codes.
`timescale 1ns / 1ps

module kld_scoreboard #(
   parameter int TABLE_BITS = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [31:0] csr_data,
   output int               error_count,
   output int               divergences_pending
);
   import kld_pkg::*;

   localparam longint          SUM_CEIL = 64'sh7FFF_FFFF_FFFF;
   localparam longint          SUM_FLOOR = -SUM_CEIL - 1;
   localparam longint unsigned LN2_FRACTION = 64'd45426;
   localparam logic [31:0]     THRESHOLD_AT_RESET = 32'd6554;
   localparam int              PRINT_LIMIT = 40;

   typedef struct packed {
      logic [31:0] divergence;
      status_type  status;
   } divergence_result_type;

   logic [15:0]           log_fraction [2**TABLE_BITS];
   longint                kl_sum;
   bit                    q_fault;
   logic [31:0]           threshold;
   divergence_result_type expected_divergences [$];
   divergence_result_type oldest;

   // Fraction of log2(1 + i / 2^TABLE_BITS), bit by bit through repeated squaring in Q1.30.
   function automatic logic [15:0] fraction_log2(int unsigned index);
      longint unsigned x;
      logic [15:0]     bits;
      x = (64'd1 << 30) + (64'(index) << (30 - TABLE_BITS));
      bits = '0;
      for (int k = 15; k >= 0; k--) begin
         x = (x * x) >> 30;
         if (x >= (64'd1 << 31)) begin
            bits[k] = 1'b1;
            x = x >> 1;
         end
      end
      return bits;
   endfunction

   initial begin
      error_count = 0;
      for (int i = 0; i < 2**TABLE_BITS; i++) begin
         log_fraction[i] = fraction_log2(i);
      end
   end

   // Signed Q16.16 log2 of a nonzero weight.
   function automatic longint log2_fixed(logic [31:0] x);
      int          lead;
      logic [31:0] mantissa;
      logic [31:0] index;
      lead = 0;
      for (int b = 0; b < 32; b++) begin
         if (x[b]) begin
            lead = b;
         end
      end
      mantissa = x - (32'd1 << lead);
      if (lead >= TABLE_BITS) begin
         index = mantissa >> (lead - TABLE_BITS);
      end else begin
         index = mantissa << (TABLE_BITS - lead);
      end
      index = index & ((32'd1 << TABLE_BITS) - 32'd1);
      return longint'(lead - 16) * 65536 + longint'(log_fraction[index]);
   endfunction

   // Folds one accepted pair into the running sum; a last pair queues its result.
   function automatic void accumulate_pair(logic [31:0] p, logic [31:0] q, logic last);
      longint                d;
      longint                term;
      longint                total;
      longint unsigned       d_mag;
      longint unsigned       ln_mag;
      longint unsigned       t_mag;
      longint unsigned       s_mag;
      divergence_result_type r;
      if (p != 0 && !q_fault) begin
         if (q == 0) begin
            q_fault = 1'b1;
         end else begin
            d = log2_fixed(p) - log2_fixed(q);
            d_mag = (d < 0) ? -d : d;
            ln_mag = (d_mag * LN2_FRACTION) >> 16;
            t_mag = (64'(p) * ln_mag) >> 16;
            term = (d < 0) ? -$signed(t_mag) : $signed(t_mag);
            total = kl_sum + term;
            if (total > SUM_CEIL) begin
               total = SUM_CEIL;
            end
            if (total < SUM_FLOOR) begin
               total = SUM_FLOOR;
            end
            kl_sum = total;
         end
      end
      if (last) begin
         if (q_fault) begin
            r = '{divergence: 32'd0, status: STATUS_FAULT};
         end else begin
            s_mag = (kl_sum < 0) ? -kl_sum : kl_sum;
            if (s_mag < 64'(threshold)) begin
               r.divergence = (s_mag > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s_mag[31:0];
               r.status = STATUS_BELOW;
            end else begin
               r = '{divergence: 32'd0, status: STATUS_ABOVE};
            end
         end
         expected_divergences = {expected_divergences, r};
         kl_sum = 0;
         q_fault = 1'b0;
      end
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("[%0t] kld_scoreboard: %s", $time, what);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kl_sum = 0;
         q_fault = 1'b0;
         threshold = THRESHOLD_AT_RESET;
         expected_divergences.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            threshold = csr_data;
         end
         if (req_tvalid && req_tready) begin
            accumulate_pair(req_tdata[31:0], req_tdata[63:32], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_divergences.size() == 0) begin
               report_mismatch($sformatf("result %h status %0d with none outstanding",
                                         rsp_tdata, rsp_tuser));
            end else begin
               oldest = expected_divergences.pop_front();
               if (rsp_tdata !== oldest.divergence) begin
                  report_mismatch($sformatf("divergence %h, predicted %h",
                                            rsp_tdata, oldest.divergence));
               end
               if (rsp_tuser !== oldest.status) begin
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_tuser, oldest.status));
               end
            end
         end
      end
      divergences_pending <= expected_divergences.size();
   end

endmodule

[tb/sv/kl_divergence_threshold_tb.sv]
// Top of the testbench for kl_divergence_threshold: clock, reset, pair stimulus,
// threshold writes, result back-pressure and the verdict. Depends on the block's
// RTL, kld_pkg and kld_scoreboard, which does all prediction and comparison.
`timescale 1ns / 1ps

module kl_divergence_threshold_tb;

   localparam int TABLE_BITS = 6;
   // Up to four pairs can sit between the input and the result register; the settle
   // time covers any work still in flight once the last result has arrived.
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS = 200;
   localparam int PHASE_COUNT = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   // About 1400 transfers at their worst-case pace, taken ten times over.
   localparam int CYCLE_LIMIT = 500000;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   int            error_count;
   int            divergences_pending;
   int            cycle_count = 0;
   int            sent_pairs = 0;
   idle_mode_type idle_mode = IDLE_NONE;
   int unsigned   sender_gap_pct;
   int unsigned   receiver_stall_pct;
   // A long receiver hold-off starts whenever hold_epoch moves; the receiver
   // process keeps its own count of the stalled cycles.
   int            hold_epoch = 0;
   int            hold_seen = 0;
   int            hold_left = 0;

   assign sender_gap_pct = (idle_mode == IDLE_SENDER) ? 83 : (idle_mode == IDLE_BOTH) ? 11 : 0;
   assign receiver_stall_pct =
      (idle_mode == IDLE_RECEIVER) ? 83 : (idle_mode == IDLE_BOTH) ? 11 : 0;

   kl_divergence_threshold #(
      .LOG_TABLE_BITS(TABLE_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   kld_scoreboard #(
      .TABLE_BITS(TABLE_BITS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .error_count(error_count),
      .divergences_pending(divergences_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("kl_divergence_threshold: mismatch");
         $finish;
      end
   end

   // Result side. Outside a hold-off it stalls at random according to the
   // current idle mode; during a hold-off it refuses every transfer so that the
   // result register, the queue and the front end all fill and req_tready drops.
   always @(posedge clock) begin
      if (hold_epoch != hold_seen) begin
         hold_seen <= hold_epoch;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Offers one pair and returns right after the edge at which it transferred.
   // A pair that follows directly keeps req_tvalid high, so the signal never
   // gets two assignments in one time step.
   task automatic send_pair(logic [31:0] p, logic [31:0] q, logic last);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {q, p};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      if (p != 0) begin
         sent_pairs++;
      end
   endtask

   // Stops offering pairs and waits until the checker has nothing outstanding.
   // The first edge lets the checker count a pair that transferred just now.
   task automatic wait_for_results(int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (divergences_pending != 0) begin
         @(posedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_threshold(logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // A weight drawn from a mix of zero, tiny values that exercise the left-shifted
   // table index, single powers of two, values near full scale and random values
   // whose magnitude is cut down by reach.
   function automatic logic [31:0] random_weight(int unsigned reach);
      case ($urandom_range(11))
         0: return 32'd0;
         1: return $urandom_range(63, 1);
         2: return 32'd1 << $urandom_range(31);
         3: return 32'hFFFF_FFFF - $urandom_range(255);
         default: return $urandom() >> reach;
      endcase
   endfunction

   // One vector of category pairs, closed by a last pair. Many q values are drawn
   // close to p, as for two similar distributions, so that sums stay small enough
   // to land below the threshold; a few q values are zero and raise the fault.
   task automatic send_random_vector();
      int unsigned length;
      int unsigned reach;
      logic [31:0] p;
      logic [31:0] q;
      length = ($urandom_range(9) == 0) ? $urandom_range(32, 9) : $urandom_range(8, 1);
      reach = $urandom_range(31);
      for (int unsigned n = 1; n <= length; n++) begin
         p = random_weight(reach);
         case ($urandom_range(39))
            0: q = 32'd0;
            1, 2, 3, 4, 5: q = p;
            6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17:
               q = p ^ ($urandom() & ((32'd1 << $urandom_range(14)) - 32'd1));
            default: q = random_weight($urandom_range(31));
         endcase
         send_pair(p, q, n == length);
      end
   endtask

   function automatic logic [31:0] phase_threshold(int phase);
      case (phase)
         0: return 32'hFFFF_FFFF;
         1: return 32'd0;
         2: return 32'd6554;
         default: return $urandom() >> $urandom_range(24);
      endcase
   endfunction

   initial begin : stimulus
      int target;
      int pause_at;
      bit paused;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed vectors under the reset threshold of 0.1.
      // An empty sum from a vector of only zero-weight pairs.
      send_pair(32'd0, 32'd0, 1'b1);
      // Zero p with full-scale q adds nothing; equal weights add a zero term.
      send_pair(32'd0, 32'hFFFF_FFFF, 1'b0);
      send_pair(32'h0001_0000, 32'h0001_0000, 1'b1);
      // The largest positive term, then a tiny negative one.
      send_pair(32'hFFFF_FFFF, 32'd1, 1'b1);
      send_pair(32'd1, 32'hFFFF_FFFF, 1'b1);
      // A zero q raises the fault; later terms are ignored until the last pair.
      send_pair(32'h0000_8000, 32'd0, 1'b0);
      send_pair(32'hFFFF_FFFF, 32'd1, 1'b0);
      send_pair(32'd0, 32'd0, 1'b1);
      // A fault on the last pair itself.
      send_pair(32'd5, 32'd0, 1'b1);
      // Tiny weights, whose table index is shifted up from below the leading one.
      send_pair(32'd0, 32'd0, 1'b0);
      send_pair(32'd3, 32'd7, 1'b0);
      send_pair(32'd63, 32'd1, 1'b0);
      send_pair(32'd1, 32'd2, 1'b1);
      // Powers of two, and two terms that nearly cancel.
      send_pair(32'h8000_0000, 32'h4000_0000, 1'b1);
      send_pair(32'h0000_FFFF, 32'h0001_0000, 1'b0);
      send_pair(32'h0001_0000, 32'h0000_FFFF, 1'b1);

      // Threshold of zero: even an empty sum is at or above it.
      wait_for_results(SETTLE_CYCLES);
      write_threshold(32'd0);
      send_pair(32'd0, 32'd0, 1'b1);
      send_pair(32'd2, 32'd1, 1'b1);

      // Full-scale threshold: one sum below it and one above it.
      wait_for_results(SETTLE_CYCLES);
      write_threshold(32'hFFFF_FFFF);
      send_pair(32'h1000_0000, 32'h0800_0000, 1'b1);
      send_pair(32'hFFFF_FFFF, 32'h0001_0000, 1'b1);

      // Random phases, each under its own threshold and idle pattern.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_for_results(SETTLE_CYCLES);
         write_threshold(phase_threshold(phase));
         idle_mode <= idle_mode_type'(phase % 4);
         if (phase == 4) begin
            // The receiver holds off while pairs keep coming with no gaps.
            hold_epoch <= hold_epoch + 1;
         end
         target = sent_pairs + PHASE_ITEMS;
         pause_at = sent_pairs + PHASE_ITEMS / 2;
         paused = 1'b0;
         while (sent_pairs < target) begin
            send_random_vector();
            if (phase == 5 && !paused && sent_pairs >= pause_at) begin
               // Mid-phase the sender goes quiet until every result is back.
               wait_for_results(0);
               paused = 1'b1;
            end
         end
      end

      idle_mode <= IDLE_NONE;
      wait_for_results(SETTLE_CYCLES);
      if (error_count == 0) begin
         $display("kl_divergence_threshold: match");
      end else begin
         $display("kl_divergence_threshold: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
rtl/kld_pkg.sv
rtl/kld_front.sv
rtl/kld_queue.sv
rtl/kld_back.sv
rtl/kl_divergence_threshold.sv
rtl/kld_checker.sv
tb/sv/kld_checker.sv
tb/sv/kl_divergence_threshold_tb.sv
